// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

// ===== src/btem_pkg.sv =====
`timescale 1ns / 1ps

package btem_pkg;

    localparam int STEP_W = 23;
    localparam int ATT_W  = 10;
    localparam int REL_W  = 12;
    localparam int LEN_W  = 24;
    localparam int SMP_W  = 16;
    localparam int IDX_W  = 2;

    // Divider sizing: numerator is at most 4095 * 5242, quotient at most 5242.
    localparam int NUM_W  = 25;
    localparam int DEN_W  = 12;
    localparam int Q_W    = 13;
    localparam int QCNT_W = 4;

    localparam logic [Q_W-1:0] TONE_AMP = 13'd5242;

    localparam logic [IDX_W-1:0] REG_PHASE_STEP = 2'd0;
    localparam logic [IDX_W-1:0] REG_ATTACK     = 2'd1;
    localparam logic [IDX_W-1:0] REG_RELEASE    = 2'd2;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_FRAME = 1'b1;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic           busy;
        logic           done;
        logic [Q_W-1:0] quot;
    } t_div_rsp;

endpackage

// ===== src/btem_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle, MSB first.
module btem_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  btem_pkg::t_div_req i_req,
    output btem_pkg::t_div_rsp o_rsp
);
    import btem_pkg::*;

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [QCNT_W-1:0] r_cnt,  n_cnt;
    logic [NUM_W-1:0]  r_rem,  n_rem;
    logic [DEN_W-1:0]  r_den,  n_den;
    logic [Q_W-1:0]    r_quot, n_quot;
    logic [NUM_W-1:0]  w_sub;
    logic              w_fit;

    assign w_sub = NUM_W'(r_den) << r_cnt;
    assign w_fit = (r_rem >= w_sub);

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_quot = r_quot;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = QCNT_W'(Q_W - 1);
            n_rem  = i_req.num;
            n_den  = i_req.den;
            n_quot = '0;
        end else if (r_busy) begin
            if (w_fit) begin
                n_rem = r_rem - w_sub;
            end
            n_quot = {r_quot[Q_W-2:0], w_fit};
            n_cnt  = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_quot <= n_quot;
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

// ===== src/beeper_tone_envelope_mixer_core.sv =====
`timescale 1ns / 1ps
// Start beat: taken with no result; the block is ready again next cycle.
// Frame beat: result registered by the mix step after the attack and release steps;
// the shared 13-step divider runs for the attack and release limits, each only while
// the count sits inside that ramp. No new beat is taken until the sequencer is idle
// again; the mix step holds while the output slot is stalled.
// Reset (i_rst_n low, synchronous): counters, phase and output valid clear,
// configuration registers return to their defaults.

`include "assert_macros.svh"

module beeper_tone_envelope_mixer_core #(
    parameter int PHASE_BITS = 24,
    parameter int COUNT_BITS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [btem_pkg::IDX_W-1:0]          i_cfg_index,
    input  logic [btem_pkg::STEP_W-1:0]         i_cfg_data,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_command,
    input  logic [btem_pkg::LEN_W-1:0]          i_beep_length,
    input  logic signed [btem_pkg::SMP_W-1:0]   i_in_left,
    input  logic signed [btem_pkg::SMP_W-1:0]   i_in_right,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [btem_pkg::SMP_W-1:0]   o_out_left,
    output logic signed [btem_pkg::SMP_W-1:0]   o_out_right,
    output logic                                o_tone_active
);
    import btem_pkg::*;

    // Sequencer codes
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_ATT_MUL = 3'd1;
    localparam logic [2:0] S_ATT_DIV = 3'd2;
    localparam logic [2:0] S_REL_MUL = 3'd3;
    localparam logic [2:0] S_REL_DIV = 3'd4;
    localparam logic [2:0] S_MIX     = 3'd5;

    // Saturate a 17-bit sum into the 16-bit sample range.
    function automatic logic signed [SMP_W-1:0] sat16(input logic signed [SMP_W:0] v);
        logic signed [SMP_W-1:0] res;
        if (v[SMP_W] != v[SMP_W-1]) begin
            res = v[SMP_W] ? {1'b1, {(SMP_W-1){1'b0}}} : {1'b0, {(SMP_W-1){1'b1}}};
        end else begin
            res = v[SMP_W-1:0];
        end
        return res;
    endfunction

    // Configuration registers
    logic [STEP_W-1:0]     r_step;
    logic [ATT_W-1:0]      r_att;
    logic [REL_W-1:0]      r_rel;

    // Beep state
    logic [2:0]            r_state,     n_state;
    logic [COUNT_BITS-1:0] r_remaining, n_remaining;
    logic [COUNT_BITS-1:0] r_total,     n_total;
    logic [PHASE_BITS-1:0] r_phase,     n_phase;

    // Per-frame working registers
    logic                  r_active,    n_active;
    logic [Q_W-1:0]        r_mag,       n_mag;
    logic signed [SMP_W-1:0] r_left,    n_left;
    logic signed [SMP_W-1:0] r_right,   n_right;

    // Output register
    logic                  r_out_valid, n_out_valid;
    logic signed [SMP_W-1:0] r_out_left,  n_out_left;
    logic signed [SMP_W-1:0] r_out_right, n_out_right;
    logic                  r_out_active, n_out_active;

    logic                  w_in_acc;
    logic                  w_out_free;
    logic [COUNT_BITS-1:0] w_done;
    logic                  w_att_hit;
    logic                  w_rel_hit;
    logic [NUM_W-1:0]      w_att_prod;
    logic [NUM_W-1:0]      w_rel_prod;
    logic signed [Q_W:0]   w_tone;
    logic signed [SMP_W:0] w_sum_l;
    logic signed [SMP_W:0] w_sum_r;
    t_div_req              w_div_req;
    t_div_rsp              w_div_rsp;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    // Output slot can take a new result when empty or being drained this cycle.
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Envelope limits are only needed when the count sits inside a ramp; then the
    // operand fits the ramp register width, which keeps the multiply narrow.
    assign w_done     = r_total - r_remaining;
    assign w_att_hit  = r_active && (r_att != '0) && (w_done < COUNT_BITS'(r_att));
    assign w_rel_hit  = r_active && (r_rel != '0) && (r_remaining < COUNT_BITS'(r_rel));
    assign w_att_prod = NUM_W'(w_done[ATT_W-1:0]) * NUM_W'(TONE_AMP);
    assign w_rel_prod = NUM_W'(r_remaining[REL_W-1:0]) * NUM_W'(TONE_AMP);

    // Product lands straight in the divider's remainder register.
    assign w_div_req.start = ((r_state == S_ATT_MUL) && w_att_hit) ||
                             ((r_state == S_REL_MUL) && w_rel_hit);
    assign w_div_req.num   = (r_state == S_ATT_MUL) ? w_att_prod : w_rel_prod;
    assign w_div_req.den   = (r_state == S_ATT_MUL) ? DEN_W'(r_att) : DEN_W'(r_rel);

    btem_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Square tone: positive while the phase top bit is clear.
    assign w_tone  = r_phase[PHASE_BITS-1] ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});
    assign w_sum_l = (SMP_W+1)'(r_left)  + (SMP_W+1)'(w_tone);
    assign w_sum_r = (SMP_W+1)'(r_right) + (SMP_W+1)'(w_tone);

    always_comb begin
        n_state      = r_state;
        n_remaining  = r_remaining;
        n_total      = r_total;
        n_phase      = r_phase;
        n_active     = r_active;
        n_mag        = r_mag;
        n_left       = r_left;
        n_right      = r_right;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_left   = r_out_left;
        n_out_right  = r_out_right;
        n_out_active = r_out_active;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_command == CMD_START) begin
                        // Restart the beep: load both counts, clear the phase.
                        n_remaining = COUNT_BITS'(i_beep_length);
                        n_total     = COUNT_BITS'(i_beep_length);
                        n_phase     = '0;
                    end else begin
                        n_left   = i_in_left;
                        n_right  = i_in_right;
                        n_active = (r_remaining != '0);
                        n_mag    = (r_remaining != '0) ? TONE_AMP : '0;
                        n_state  = S_ATT_MUL;
                    end
                end
            end
            S_ATT_MUL: begin
                n_state = w_att_hit ? S_ATT_DIV : S_REL_MUL;
            end
            S_ATT_DIV: begin
                if (w_div_rsp.done) begin
                    if (w_div_rsp.quot < r_mag) begin
                        n_mag = w_div_rsp.quot;
                    end
                    n_state = S_REL_MUL;
                end
            end
            S_REL_MUL: begin
                n_state = w_rel_hit ? S_REL_DIV : S_MIX;
            end
            S_REL_DIV: begin
                if (w_div_rsp.done) begin
                    if (w_div_rsp.quot < r_mag) begin
                        n_mag = w_div_rsp.quot;
                    end
                    n_state = S_MIX;
                end
            end
            S_MIX: begin
                // Hold until the output slot frees, then publish; advance the beep only while active.
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_left   = sat16(w_sum_l);
                    n_out_right  = sat16(w_sum_r);
                    n_out_active = r_active;
                    if (r_active) begin
                        n_phase     = r_phase + PHASE_BITS'(r_step);
                        n_remaining = r_remaining - 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_remaining <= '0;
            r_total     <= '0;
            r_phase     <= '0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_remaining <= n_remaining;
            r_total     <= n_total;
            r_phase     <= n_phase;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
        r_mag        <= n_mag;
        r_left       <= n_left;
        r_right      <= n_right;
        r_out_left   <= n_out_left;
        r_out_right  <= n_out_right;
        r_out_active <= n_out_active;
    end

    // Configuration writes; indexes past the list drop silently.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_W'(341045);
            r_att  <= ATT_W'(220);
            r_rel  <= REL_W'(604);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_PHASE_STEP: r_step <= i_cfg_data;
                REG_ATTACK:     r_att  <= i_cfg_data[ATT_W-1:0];
                REG_RELEASE:    r_rel  <= i_cfg_data[REL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_left    = r_out_left;
    assign o_out_right   = r_out_right;
    assign o_tone_active = r_out_active;

    // The divider only runs while the sequencer waits on it.
    `ASSERT_CLK(a_div_owned, i_clk, i_rst_n, w_div_rsp.busy |-> (r_state == S_ATT_DIV || r_state == S_REL_DIV))
    // Envelope never exceeds the full tone amplitude.
    `ASSERT_NEVER(a_mag_bound, i_clk, i_rst_n, r_state == S_MIX && r_mag > TONE_AMP)
    // Remaining count moves only on a start beat or when a frame is published.
    `ASSERT_CLK(a_cnt_move, i_clk, i_rst_n, (r_remaining != $past(r_remaining)) |-> ($past(r_state) == S_MIX || $past(w_in_acc)))
    // A fresh result is published only from the mix step.
    `ASSERT_CLK(a_out_src, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(r_state) == S_MIX)

endmodule
